/* hw/rtl/fmgs_pkg.sv */
// ============================================================================
// fmgs_pkg - shared types and constants of the fuzzy motor gain scheduler
// Breakpoints, rule table, clamp limits and field types used by all stages.
// ============================================================================
`default_nettype none

package fmgs_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int ERR_W = 16;
    localparam int KP_W  = 12;
    localparam int KI_W  = 11;

    localparam int ERR_LIM = 400;
    localparam int DIF_LIM = 200;
    localparam int NUM_BP  = 7;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [9:0]       errc_t;
    typedef logic signed [8:0]       difc_t;
    typedef logic [2:0]              seg_t;
    typedef logic [7:0]              ofs_t;
    typedef logic signed [3:0]       rule_t;
    typedef logic signed [KP_W-1:0]  kp_t;
    typedef logic signed [KI_W-1:0]  ki_t;

    localparam seg_t SEG_FIRST = 3'd1;
    localparam seg_t SEG_LAST  = 3'd6;

    localparam errc_t ERR_BP [0:NUM_BP-1] =
        '{-10'sd400, -10'sd200, -10'sd100, 10'sd0, 10'sd100, 10'sd200, 10'sd400};
    localparam difc_t DIF_BP [0:NUM_BP-1] =
        '{-9'sd200, -9'sd100, -9'sd50, 9'sd0, 9'sd50, 9'sd100, 9'sd200};

    // Rows follow the error segment, columns the difference segment.
    localparam rule_t KP_RULES [0:NUM_BP-1][0:NUM_BP-1] = '{
        '{ 4'sd0,  4'sd0,  4'sd4,  4'sd6,  4'sd6,  4'sd6,  4'sd6},
        '{ 4'sd0,  4'sd0,  4'sd4,  4'sd4,  4'sd6,  4'sd6,  4'sd6},
        '{-4'sd4, -4'sd4,  4'sd0,  4'sd4,  4'sd4,  4'sd4,  4'sd6},
        '{-4'sd2, -4'sd2, -4'sd2,  4'sd0,  4'sd4,  4'sd4,  4'sd4},
        '{-4'sd6, -4'sd4, -4'sd4, -4'sd4,  4'sd0,  4'sd2,  4'sd2},
        '{-4'sd6, -4'sd6, -4'sd6, -4'sd4,  4'sd0,  4'sd0,  4'sd0},
        '{-4'sd6, -4'sd6, -4'sd6, -4'sd6, -4'sd6, -4'sd2,  4'sd0}
    };

endpackage

`default_nettype wire

/* hw/rtl/fmgs_in_if.sv */
// ============================================================================
// fmgs_in_if - error pair channel
// Valid/ready channel carrying the current and the previous speed error.
// ============================================================================
`default_nettype none

interface fmgs_in_if;
    logic                valid;
    logic                ready;
    fmgs_pkg::err_t      speed_error;
    fmgs_pkg::err_t      previous_error;

    modport source (output valid, output speed_error, output previous_error, input ready);
    modport sink   (input valid, input speed_error, input previous_error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fmgs_out_if.sv */
// ============================================================================
// fmgs_out_if - gain channel
// Valid/ready channel carrying the scheduled Kp and Ki adjustments.
// ============================================================================
`default_nettype none

interface fmgs_out_if;
    logic                valid;
    logic                ready;
    fmgs_pkg::kp_t       kp_gain;
    fmgs_pkg::ki_t       ki_gain;

    modport source (output valid, output kp_gain, output ki_gain, input ready);
    modport sink   (input valid, input kp_gain, input ki_gain, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fmgs_front.sv */
// ============================================================================
// fmgs_front - clamp and segment search
// Stage 1 clamps error and difference, stage 2 finds the segments and
// scales the offset into each segment onto a common 0..200 span.
// ============================================================================
`default_nettype none

module fmgs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fmgs_pkg::err_t  speed_error,
    input  fmgs_pkg::err_t  previous_error,
    output logic            out_valid,
    input  logic            out_ready,
    output fmgs_pkg::seg_t  seg_a,
    output fmgs_pkg::ofs_t  ofs_a,
    output fmgs_pkg::seg_t  seg_b,
    output fmgs_pkg::ofs_t  ofs_b
);
    import fmgs_pkg::*;

    logic               s1_valid_reg;
    logic               s1_ready;
    errc_t              ec_reg;
    errc_t              ec_next;
    difc_t              dc_reg;
    difc_t              dc_next;
    logic signed [16:0] diff;

    logic               s2_valid_reg;
    logic               s2_ready;
    seg_t               seg_a_reg;
    seg_t               seg_a_next;
    seg_t               seg_b_reg;
    seg_t               seg_b_next;
    ofs_t               ofs_a_reg;
    ofs_t               ofs_a_next;
    ofs_t               ofs_b_reg;
    ofs_t               ofs_b_next;
    logic signed [10:0] rel_a;
    logic signed [9:0]  rel_b;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: difference at full precision, then clamp both.
    always_comb
    begin
        diff = 17'(speed_error) - 17'(previous_error);
        priority if (speed_error > ERR_LIM)
            ec_next = errc_t'(ERR_LIM);
        else if (speed_error < -ERR_LIM)
            ec_next = errc_t'(-ERR_LIM);
        else
            ec_next = speed_error[9:0];
        priority if (diff > DIF_LIM)
            dc_next = difc_t'(DIF_LIM);
        else if (diff < -DIF_LIM)
            dc_next = difc_t'(-DIF_LIM);
        else
            dc_next = diff[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            ec_reg <= ec_next;
            dc_reg <= dc_next;
        end
    end

    // Stage 2: a value on a breakpoint stays in the lower segment.
    always_comb
    begin
        seg_a_next = SEG_FIRST;
        seg_b_next = SEG_FIRST;
        for (int k = 1; k < NUM_BP - 1; k++)
        begin
            if (ec_reg > ERR_BP[k])
                seg_a_next = seg_a_next + 3'd1;
            if (dc_reg > DIF_BP[k])
                seg_b_next = seg_b_next + 3'd1;
        end
        rel_a = 11'(ec_reg) - 11'(ERR_BP[seg_a_next - 3'd1]);
        rel_b = 10'(dc_reg) - 10'(DIF_BP[seg_b_next - 3'd1]);
        // Outer segments are twice as wide as the inner ones.
        if (seg_a_next == SEG_FIRST || seg_a_next == SEG_LAST)
            ofs_a_next = rel_a[7:0];
        else
            ofs_a_next = {rel_a[6:0], 1'b0};
        if (seg_b_next == SEG_FIRST || seg_b_next == SEG_LAST)
            ofs_b_next = {rel_b[6:0], 1'b0};
        else
            ofs_b_next = {rel_b[5:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            seg_a_reg <= seg_a_next;
            seg_b_reg <= seg_b_next;
            ofs_a_reg <= ofs_a_next;
            ofs_b_reg <= ofs_b_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign seg_a     = seg_a_reg;
    assign seg_b     = seg_b_reg;
    assign ofs_a     = ofs_a_reg;
    assign ofs_b     = ofs_b_reg;

endmodule

`default_nettype wire

/* hw/rtl/fmgs_weight.sv */
// ============================================================================
// fmgs_weight - weights and rule fetch
// Stage 3 turns each scaled offset into a floored fixed-point weight by a
// reciprocal multiply and fetches the four corner entries of the rule table.
// ============================================================================
`default_nettype none

module fmgs_weight #(
    parameter int FRAC_BITS = fmgs_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fmgs_pkg::seg_t        seg_a,
    input  fmgs_pkg::ofs_t        ofs_a,
    input  fmgs_pkg::seg_t        seg_b,
    input  fmgs_pkg::ofs_t        ofs_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FRAC_BITS:0]    wa,
    output logic [FRAC_BITS:0]    wb,
    output fmgs_pkg::rule_t       t00,
    output fmgs_pkg::rule_t       t01,
    output fmgs_pkg::rule_t       t10,
    output fmgs_pkg::rule_t       t11
);
    import fmgs_pkg::*;

    // floor(n * 2^F / 200) for n <= 200 equals (n * RECIP) >> 16 exactly.
    localparam int              RECIP_SH = 16;
    localparam int              RECIP_W  = FRAC_BITS + 9;
    localparam int              PROD_W   = RECIP_W + 8;
    localparam longint unsigned RECIP_L  =
        ((64'd1 << (FRAC_BITS + RECIP_SH)) + 64'd199) / 64'd200;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic                 valid_reg;
    logic                 stage_ready;
    logic [PROD_W-1:0]    prod_a;
    logic [PROD_W-1:0]    prod_b;
    logic [FRAC_BITS:0]   wa_reg;
    logic [FRAC_BITS:0]   wb_reg;
    rule_t                t00_reg;
    rule_t                t01_reg;
    rule_t                t10_reg;
    rule_t                t11_reg;
    seg_t                 row_lo;
    seg_t                 col_lo;

    assign stage_ready = !valid_reg || out_ready;
    assign in_ready    = stage_ready;

    assign prod_a = PROD_W'(ofs_a) * PROD_W'(RECIP);
    assign prod_b = PROD_W'(ofs_b) * PROD_W'(RECIP);
    assign row_lo = seg_a - 3'd1;
    assign col_lo = seg_b - 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (stage_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && in_valid)
        begin
            wa_reg  <= prod_a[PROD_W-1:RECIP_SH];
            wb_reg  <= prod_b[PROD_W-1:RECIP_SH];
            t00_reg <= KP_RULES[row_lo][col_lo];
            t01_reg <= KP_RULES[row_lo][seg_b];
            t10_reg <= KP_RULES[seg_a][col_lo];
            t11_reg <= KP_RULES[seg_a][seg_b];
        end
    end

    assign out_valid = valid_reg;
    assign wa        = wa_reg;
    assign wb        = wb_reg;
    assign t00       = t00_reg;
    assign t01       = t01_reg;
    assign t10       = t10_reg;
    assign t11       = t11_reg;

endmodule

`default_nettype wire

/* hw/rtl/fmgs_blend.sv */
// ============================================================================
// fmgs_blend - bilinear interpolation
// Stage 4 interpolates both table rows along the difference, stage 5 blends
// the rows along the error and holds the result for the output transfer.
// ============================================================================
`default_nettype none

module fmgs_blend #(
    parameter int FRAC_BITS = fmgs_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FRAC_BITS:0]    wa,
    input  logic [FRAC_BITS:0]    wb,
    input  fmgs_pkg::rule_t       t00,
    input  fmgs_pkg::rule_t       t01,
    input  fmgs_pkg::rule_t       t10,
    input  fmgs_pkg::rule_t       t11,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fmgs_pkg::kp_t         kp_gain,
    output fmgs_pkg::ki_t         ki_gain
);
    import fmgs_pkg::*;

    localparam int RW     = FRAC_BITS + 4;
    localparam int SW     = 2 * FRAC_BITS + 4;
    localparam int KP_LSB = 2 * FRAC_BITS - 8;
    localparam int KI_LSB = KP_LSB + 1;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                  s4_valid_reg;
    logic                  s4_ready;
    logic signed [RW-1:0]  rlo_reg;
    logic signed [RW-1:0]  rlo_next;
    logic signed [RW-1:0]  rhi_reg;
    logic signed [RW-1:0]  rhi_next;
    logic [FRAC_BITS:0]    wa_reg;
    logic [FRAC_BITS:0]    wb_inv;
    logic [FRAC_BITS:0]    wa_inv;

    logic                  s5_valid_reg;
    logic                  s5_ready;
    logic signed [SW-1:0]  sum_reg;
    logic signed [SW-1:0]  sum_next;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // Stage 4: row i-1 and row i, each blended along the difference.
    assign wb_inv   = ONE - wb;
    assign rlo_next = RW'(t00) * RW'($signed({1'b0, wb_inv}))
                    + RW'(t01) * RW'($signed({1'b0, wb}));
    assign rhi_next = RW'(t10) * RW'($signed({1'b0, wb_inv}))
                    + RW'(t11) * RW'($signed({1'b0, wb}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (s4_ready)
            s4_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && in_valid)
        begin
            rlo_reg <= rlo_next;
            rhi_reg <= rhi_next;
            wa_reg  <= wa;
        end
    end

    // Stage 5: blend the rows along the error.
    assign wa_inv   = ONE - wa_reg;
    assign sum_next = SW'(rlo_reg) * SW'($signed({1'b0, wa_inv}))
                    + SW'(rhi_reg) * SW'($signed({1'b0, wa_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (s5_ready)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && s4_valid_reg)
            sum_reg <= sum_next;
    end

    // Keep the top eight fraction bits: two's complement selection floors.
    // Rule entries are all even, so the halved table is the sum halved.
    assign out_valid = s5_valid_reg;
    assign kp_gain   = sum_reg[KP_LSB +: KP_W];
    assign ki_gain   = sum_reg[KI_LSB +: KI_W];

endmodule

`default_nettype wire

/* hw/rtl/fuzzy_motor_gain_schedule_core.sv */
// Throughput: one error pair per cycle unless stalled; five register stages
// (clamp, segment search, reciprocal weight multiply, row blend, row-to-row
// blend). A stall holds every stage and only fills empty slots ahead of it.
// Reset clears the stage valid bits; no state carries between items.
// ============================================================================
// fuzzy_motor_gain_schedule_core - fuzzy Kp/Ki gain scheduler
// Bilinear interpolation of a 7x7 rule table over clamped speed error and
// error difference, producing Q8 Kp and Ki adjustments.
// ============================================================================
`default_nettype none

module fuzzy_motor_gain_schedule_core #(
    parameter int FRAC_BITS = fmgs_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fmgs_in_if.sink     err_in,
    fmgs_out_if.source  gain_out
);
    import fmgs_pkg::*;

    logic               front_valid;
    logic               front_ready;
    seg_t               seg_a;
    seg_t               seg_b;
    ofs_t               ofs_a;
    ofs_t               ofs_b;

    logic               wt_valid;
    logic               wt_ready;
    logic [FRAC_BITS:0] wa;
    logic [FRAC_BITS:0] wb;
    rule_t              t00;
    rule_t              t01;
    rule_t              t10;
    rule_t              t11;

    fmgs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (err_in.valid),
        .in_ready       (err_in.ready),
        .speed_error    (err_in.speed_error),
        .previous_error (err_in.previous_error),
        .out_valid      (front_valid),
        .out_ready      (front_ready),
        .seg_a          (seg_a),
        .ofs_a          (ofs_a),
        .seg_b          (seg_b),
        .ofs_b          (ofs_b)
    );

    fmgs_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .seg_a     (seg_a),
        .ofs_a     (ofs_a),
        .seg_b     (seg_b),
        .ofs_b     (ofs_b),
        .out_valid (wt_valid),
        .out_ready (wt_ready),
        .wa        (wa),
        .wb        (wb),
        .t00       (t00),
        .t01       (t01),
        .t10       (t10),
        .t11       (t11)
    );

    fmgs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wt_valid),
        .in_ready  (wt_ready),
        .wa        (wa),
        .wb        (wb),
        .t00       (t00),
        .t01       (t01),
        .t10       (t10),
        .t11       (t11),
        .out_valid (gain_out.valid),
        .out_ready (gain_out.ready),
        .kp_gain   (gain_out.kp_gain),
        .ki_gain   (gain_out.ki_gain)
    );

endmodule

`default_nettype wire
